/* hw/rtl/hufftd_pkg.sv */
// ============================================================================
// hufftd_pkg: shared definitions for the Huffman table decoder
// Opcodes, default parameters, field widths and tdata layout of the input.
// ============================================================================
package hufftd_pkg;

    // Default sizing handed to the top level.
    localparam int NODE_COUNT_DEF   = 255;
    localparam int LENGTH_WIDTH_DEF = 24;

    // Input item kinds, carried on s_axis_tuser.
    localparam int          OPCODE_W  = 2;
    localparam logic [1:0]  OP_LOAD   = 2'd0;
    localparam logic [1:0]  OP_START  = 2'd1;
    localparam logic [1:0]  OP_DATA   = 2'd2;

    // Field widths.
    localparam int NODE_W   = 8;
    localparam int CHILD_W  = 9;
    localparam int EXPAND_W = 24;
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = 2 * CHILD_W;

    // Input tdata layout, lowest bit first.
    localparam int NODE_LSB   = 0;
    localparam int CZERO_LSB  = NODE_LSB + NODE_W;
    localparam int CONE_LSB   = CZERO_LSB + CHILD_W;
    localparam int EXPAND_LSB = CONE_LSB + CHILD_W;
    localparam int BYTE_LSB   = EXPAND_LSB + EXPAND_W;
    localparam int S_TDATA_W  = ((BYTE_LSB + BYTE_W + 7) / 8) * 8;

    // Walk constants.
    localparam logic [NODE_W-1:0] HEAD_NODE = 8'd254;
    localparam logic [2:0]        BIT_LAST  = 3'd7;

    // Symbol waiting for the next leaf or the end of the byte.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] sym;
        logic              done;
    } pend_t;

endpackage

/* hw/rtl/huffman_table_decoder.sv */
// ============================================================================
// huffman_table_decoder: table-walking Huffman byte decoder
// Walks a code tree stored as a node table, one compressed bit per cycle while the output keeps up.
// ============================================================================
// Usage. Input items arrive on the s_axis channel; s_axis_tuser says what the
// item is: load a node entry, start a chunk with its expanded length, or
// supply a compressed byte. Decoded symbols leave on the m_axis channel, one
// item per symbol, with m_axis_tuser marking the last symbol decoded from a
// compressed byte and m_axis_tlast marking the symbol that completes a chunk.
// Load and start items are handled as they are accepted. A compressed byte is
// shifted out of a bit register least significant bit first; the bits are
// walked one at a time because the next node index comes from the node
// memory read of the bit before it. A byte thus occupies the block through
// its walk and a flush state that releases the held symbol, and no new item
// is accepted until the block is idle again; a byte that ends a chunk early
// leaves the walk sooner. Symbols follow as they are found. The block holds
// one symbol back until it knows whether another follows from the same byte.
// When the receiver stalls, the output register and the held symbol fill and
// the walk pauses at its next leaf until the output register drains. Reset
// returns the walk to the head node and clears the remaining length; the
// node memory is not cleared, so entries must be loaded before use.
// ============================================================================
module huffman_table_decoder #(
    parameter int NODE_COUNT   = hufftd_pkg::NODE_COUNT_DEF,
    parameter int LENGTH_WIDTH = hufftd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: node_index[7:0], child_zero[16:8], child_one[25:17],
    //        expand_length[49:26], data_byte[57:50], zeros above
    input  logic [hufftd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [hufftd_pkg::OPCODE_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: symbol[7:0]
    output logic [7:0]                      m_axis_tdata,
    // tuser: last_of_byte[0]
    output logic                            m_axis_tuser,
    // tlast: chunk_done
    output logic                            m_axis_tlast
);
    import hufftd_pkg::*;

    localparam int                IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(NODE_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Input field views.
    logic                    in_fire;
    logic [OPCODE_W-1:0]     in_op;
    logic [NODE_W-1:0]       in_node;
    logic [CHILD_W-1:0]      in_czero;
    logic [CHILD_W-1:0]      in_cone;
    logic [EXPAND_W-1:0]     in_len;
    logic [BYTE_W-1:0]       in_byte;

    // Node memory and its registered read port.
    logic [ENTRY_W-1:0]      node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0]      rd_reg;
    logic                    oob_reg;
    logic [NODE_W-1:0]       rd_addr;

    // Walk state.
    logic [1:0]              state_reg, state_next;
    logic [NODE_W-1:0]       node_reg, node_next;
    logic [LENGTH_WIDTH-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0]       bits_reg, bits_next;
    logic [2:0]              bitcnt_reg, bitcnt_next;
    pend_t                   pend_reg, pend_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]       m_sym_reg, m_sym_next;
    logic                    m_lob_reg, m_lob_next;
    logic                    m_done_reg, m_done_next;

    // Step logic.
    logic [CHILD_W-1:0]      child;
    logic                    is_leaf;
    logic                    out_free;
    logic                    step;
    logic                    last_sym;
    logic [NODE_W-1:0]       next_node;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser;
    assign in_node  = s_axis_tdata[NODE_LSB +: NODE_W];
    assign in_czero = s_axis_tdata[CZERO_LSB +: CHILD_W];
    assign in_cone  = s_axis_tdata[CONE_LSB +: CHILD_W];
    assign in_len   = s_axis_tdata[EXPAND_LSB +: EXPAND_W];
    assign in_byte  = s_axis_tdata[BYTE_LSB +: BYTE_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_sym_reg;
    assign m_axis_tuser  = m_lob_reg;
    assign m_axis_tlast  = m_done_reg;

    // The read register always holds the entry of the current node. A node
    // beyond the table reads as two literal-zero children.
    assign child     = oob_reg ? '0 : (bits_reg[0] ? rd_reg[ENTRY_W-1:CHILD_W]
                                                   : rd_reg[CHILD_W-1:0]);
    assign is_leaf   = !child[CHILD_W-1];
    assign next_node = is_leaf ? HEAD_NODE : child[NODE_W-1:0];
    assign out_free  = !m_valid_reg || m_axis_tready;
    // A branch always advances; a leaf needs room for the symbol it displaces.
    assign step      = (state_reg == ST_WALK) && (!is_leaf || !pend_reg.valid || out_free);
    assign last_sym  = (rem_reg == LENGTH_WIDTH'(1));
    assign rd_addr   = step ? next_node : node_reg;

    always_ff @(posedge aclk) begin
        if (in_fire && (in_op == OP_LOAD) && (in_node < NODE_LIMIT)) begin
            node_mem[in_node[IDX_W-1:0]] <= {in_cone, in_czero};
        end
        if (rd_addr < NODE_LIMIT) begin
            rd_reg <= node_mem[rd_addr[IDX_W-1:0]];
        end
        oob_reg <= (rd_addr >= NODE_LIMIT);
    end

    always_comb begin
        state_next   = state_reg;
        node_next    = node_reg;
        rem_next     = rem_reg;
        bits_next    = bits_reg;
        bitcnt_next  = bitcnt_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_sym_next   = m_sym_reg;
        m_lob_next   = m_lob_reg;
        m_done_next  = m_done_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_op)
                        OP_START: begin
                            rem_next  = LENGTH_WIDTH'({{(32 - EXPAND_W){1'b0}}, in_len});
                            node_next = HEAD_NODE;
                        end
                        OP_DATA: begin
                            // A byte outside a chunk is dropped.
                            if (rem_reg != '0) begin
                                bits_next   = in_byte;
                                bitcnt_next = '0;
                                state_next  = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (step) begin
                    bits_next   = bits_reg >> 1;
                    bitcnt_next = bitcnt_reg + 3'd1;
                    node_next   = next_node;
                    if (is_leaf) begin
                        rem_next = rem_reg - LENGTH_WIDTH'(1);
                        if (pend_reg.valid) begin
                            m_valid_next = 1'b1;
                            m_sym_next   = pend_reg.sym;
                            m_lob_next   = 1'b0;
                            m_done_next  = pend_reg.done;
                        end
                        pend_next.valid = 1'b1;
                        pend_next.sym   = child[BYTE_W-1:0];
                        pend_next.done  = last_sym;
                    end
                    // The byte ends after its top bit or when the chunk completes.
                    if ((bitcnt_reg == BIT_LAST) || (is_leaf && last_sym)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_reg.valid) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_sym_next      = pend_reg.sym;
                    m_lob_next      = 1'b1;
                    m_done_next     = pend_reg.done;
                    pend_next.valid = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_reg       <= HEAD_NODE;
            rem_reg        <= '0;
            pend_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            rem_reg        <= rem_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg      <= bits_next;
        bitcnt_reg    <= bitcnt_next;
        m_sym_reg     <= m_sym_next;
        m_lob_reg     <= m_lob_next;
        m_done_reg    <= m_done_next;
    end

`ifndef NO_ASSERTIONS
    // A walk only runs while the chunk still expects symbols.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (rem_reg != '0))
        else $error("walk active with no remaining length");

    // No symbol is left behind when the block takes new items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_reg.valid)
        else $error("held symbol lost on return to idle");

    // The symbol that completes a chunk also closes its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_lob_reg)
        else $error("chunk end without end of byte");

    // Releasing the held symbol presents it as the byte's last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FLUSH) && pend_reg.valid && out_free)
            |=> (m_valid_reg && m_lob_reg))
        else $error("final symbol of byte not presented");
`endif

endmodule

/* bench/huffman_table_decoder_checker.sv */
// ============================================================================
// huffman_table_decoder_checker: symbol predictor and scoreboard
// Watches both stream channels of the decoder. It keeps its own copy of the
// node table and the walk state, predicts the symbols of each accepted item,
// and compares every delivered symbol with the oldest prediction.
// ============================================================================
module huffman_table_decoder_checker #(
    parameter int NODE_COUNT   = hufftd_pkg::NODE_COUNT_DEF,
    parameter int LENGTH_WIDTH = hufftd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // tdata: node_index, child_zero, child_one, expand_length, data_byte
    input  logic [hufftd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [hufftd_pkg::OPCODE_W-1:0]  s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: symbol
    input  logic [7:0]                       m_axis_tdata,
    // tuser: last_of_byte
    input  logic                             m_axis_tuser,
    // tlast: chunk_done
    input  logic                             m_axis_tlast,
    output int                               fail_count,
    output int                               pending_count
);
    import hufftd_pkg::*;

    localparam int                 REPORT_LIMIT  = 10;
    localparam logic [CHILD_W-1:0] LITERAL_LIMIT = 9'd256;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              last_of_byte;
        logic              chunk_done;
    } symbol_t;

    typedef struct packed {
        logic [CHILD_W-1:0] one;
        logic [CHILD_W-1:0] zero;
    } node_t;

    node_t                   node_mem [0:NODE_COUNT-1];
    logic [NODE_W-1:0]       walk_node;
    logic [LENGTH_WIDTH-1:0] remaining;
    symbol_t                 expected_symbols [$];

    // Nodes past the end of the table read as two literal zero children.
    function automatic logic [CHILD_W-1:0] child_of(input logic [NODE_W-1:0] node,
                                                     input logic              take_one);
        if (node >= NODE_COUNT)
            return '0;
        return take_one ? node_mem[node].one : node_mem[node].zero;
    endfunction

    task automatic decode_item(input logic [OPCODE_W-1:0]  op,
                               input logic [S_TDATA_W-1:0] data);
        symbol_t            found [8];
        int                 n;
        int                 b;
        logic [CHILD_W-1:0] child;
        logic [BYTE_W-1:0]  bits;
        n    = 0;
        bits = data[BYTE_LSB +: BYTE_W];
        case (op)
            OP_LOAD: begin
                if (data[NODE_LSB +: NODE_W] < NODE_COUNT)
                    node_mem[data[NODE_LSB +: NODE_W]] = {data[CONE_LSB +: CHILD_W],
                                                          data[CZERO_LSB +: CHILD_W]};
            end
            OP_START: begin
                remaining = LENGTH_WIDTH'(data[EXPAND_LSB +: EXPAND_W]);
                walk_node = HEAD_NODE;
            end
            OP_DATA: begin
                // One table read per bit, LSB first; the walk stops as soon as
                // the chunk is complete and the rest of the byte is dropped.
                for (b = 0; b < BYTE_W && remaining != 0; b++) begin
                    child = child_of(walk_node, bits[b]);
                    if (child < LITERAL_LIMIT) begin
                        remaining             = remaining - 1'b1;
                        walk_node             = HEAD_NODE;
                        found[n].symbol       = child[BYTE_W-1:0];
                        found[n].last_of_byte = 1'b0;
                        found[n].chunk_done   = (remaining == 0);
                        n++;
                    end else begin
                        walk_node = child[NODE_W-1:0];
                    end
                end
                if (n > 0)
                    found[n-1].last_of_byte = 1'b1;
                for (b = 0; b < n; b++)
                    expected_symbols.push_back(found[b]);
            end
            default: ;
        endcase
    endtask

    task automatic check_symbol(input logic [7:0] sym, input logic lob, input logic done);
        symbol_t want;
        if (expected_symbols.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t: unexpected symbol %02h last_of_byte %0b chunk_done %0b",
                         $time, sym, lob, done);
            fail_count <= fail_count + 1;
        end else begin
            want = expected_symbols.pop_front();
            if (want.symbol !== sym || want.last_of_byte !== lob || want.chunk_done !== done)
            begin
                if (fail_count < REPORT_LIMIT)
                    $display("%0t: symbol mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             $time, want.symbol, want.last_of_byte, want.chunk_done,
                             sym, lob, done);
                fail_count <= fail_count + 1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            walk_node = HEAD_NODE;
            remaining = '0;
            expected_symbols.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                decode_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_symbol(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            pending_count <= expected_symbols.size();
        end
    end

endmodule

/* bench/huffman_table_decoder_test.sv */
// ============================================================================
// huffman_table_decoder_test: stimulus and verdict for the table decoder
// Loads code trees, starts chunks and feeds compressed bytes with random
// gaps and receiver stalls; a separate checker predicts every symbol.
// ============================================================================
module huffman_table_decoder_test;
    import hufftd_pkg::*;

    // The fourth opcode has no function; the block must drop such items.
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    localparam int                 RANDOM_ITEMS   = 95;
    // Random trees are built mostly from the nodes just below the head, so
    // that pointer children often land on nodes that are already loaded.
    localparam int                 TREE_LOW       = 236;
    localparam logic [NODE_W-1:0]  NODE_OUT       = 8'hFF;
    localparam logic [CHILD_W-1:0] NODE_BASE      = 9'd256;
    // The receiver stops once, for a long time, after this many symbols.
    localparam int                 HOLD_AT_SYMBOL = 30;
    localparam int                 HOLD_CYCLES    = 300;
    // Cycles allowed after the last expected symbol for stray output.
    localparam int                 DRAIN_CYCLES   = 40;
    localparam int                 RUN_LIMIT      = 2_000_000;

    logic [S_TDATA_W-1:0] FIELD_MASK;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [OPCODE_W-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    int fail_count;
    int pending_count;
    int items_sent;
    int symbols_taken;
    int random_sent;

    // Nodes written so far. A pointer child only ever names one of these, so
    // the walk never reaches an entry that holds no data.
    bit node_loaded [0:NODE_COUNT_DEF-1];

    assign FIELD_MASK = (S_TDATA_W'(1) << (BYTE_LSB + BYTE_W)) - 1'b1;

    huffman_table_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    huffman_table_decoder_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The fields an item does not use carry random bits, so the block is
    // shown that it must ignore them. Only the padding above stays zero.
    function automatic logic [S_TDATA_W-1:0] random_payload();
        logic [S_TDATA_W-1:0] p;
        p = {$urandom, $urandom};
        return p & FIELD_MASK;
    endfunction

    // A child is either a literal byte or a pointer to a loaded tree node.
    function automatic logic [CHILD_W-1:0] pick_child();
        int n;
        int tries;
        if ($urandom_range(0, 9) < 6)
            return CHILD_W'($urandom_range(0, 255));
        n = $urandom_range(TREE_LOW, NODE_COUNT_DEF - 1);
        for (tries = 0; tries < 8 && !node_loaded[n]; tries++)
            n = $urandom_range(TREE_LOW, NODE_COUNT_DEF - 1);
        if (!node_loaded[n])
            n = HEAD_NODE;
        return NODE_BASE + CHILD_W'(n);
    endfunction

    // Offers one item after a random gap and holds it until it is taken.
    // A stretch of items in the middle of the run goes out back to back.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = (items_sent >= 40 && items_sent < 70) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_load(input logic [NODE_W-1:0]  idx,
                             input logic [CHILD_W-1:0] c_zero,
                             input logic [CHILD_W-1:0] c_one);
        logic [S_TDATA_W-1:0] p;
        p = random_payload();
        p[NODE_LSB  +: NODE_W]  = idx;
        p[CZERO_LSB +: CHILD_W] = c_zero;
        p[CONE_LSB  +: CHILD_W] = c_one;
        send_item(OP_LOAD, p);
    endtask

    task automatic send_start(input logic [EXPAND_W-1:0] len);
        logic [S_TDATA_W-1:0] p;
        p = random_payload();
        p[EXPAND_LSB +: EXPAND_W] = len;
        send_item(OP_START, p);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] data_byte);
        logic [S_TDATA_W-1:0] p;
        p = random_payload();
        p[BYTE_LSB +: BYTE_W] = data_byte;
        send_item(OP_DATA, p);
    endtask

    // A random node write. The node is marked first so that it may point at
    // itself; an index past the table is sent now and then and must be
    // dropped by the block.
    task automatic load_random_node();
        logic [NODE_W-1:0] idx;
        int                r;
        r = $urandom_range(0, 19);
        if (r == 0)
            idx = NODE_OUT;
        else if (r < 5)
            idx = NODE_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        else
            idx = NODE_W'($urandom_range(TREE_LOW, NODE_COUNT_DEF - 1));
        if (idx < NODE_COUNT_DEF)
            node_loaded[idx] = 1'b1;
        send_load(idx, pick_child(), pick_child());
    endtask

    // The receiver waits a random gap before each symbol, takes symbols
    // without pause for a stretch, and once stops for a long time while the
    // sender keeps offering, so the output side fills and the input stalls.
    initial begin : sink
        int gap;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (symbols_taken == HOLD_AT_SYMBOL)
                gap = HOLD_CYCLES;
            else if (symbols_taken >= 60 && symbols_taken < 110)
                gap = 0;
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            symbols_taken++;
        end
    end

    initial begin : stimulus
        int                  loads;
        int                  bytes;
        int                  k;
        int                  r;
        logic [EXPAND_W-1:0] len;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. A small tree: head bit 0 goes to node 253, whose
        // bit 0 goes to node 0; every other child is a literal.
        node_loaded[0]         = 1'b1;
        node_loaded[HEAD_NODE] = 1'b1;
        node_loaded[253]       = 1'b1;
        send_load(8'd0, 9'd0, 9'd255);
        send_load(NODE_OUT, 9'd510, 9'd510);         // past the table, dropped
        send_load(8'd253, NODE_BASE + 9'd0, 9'hA5);
        send_load(HEAD_NODE, NODE_BASE + 9'd253, 9'h5A);
        send_data(8'h00);                            // no chunk open yet
        send_start(24'd0);                           // empty chunk
        send_data(8'h3C);                            // still nothing to do
        send_item(OP_NONE, random_payload());
        send_start(24'd5);
        send_data(8'hFF);                            // chunk ends mid-byte
        send_data(8'h00);                            // after the end, dropped
        send_start(24'hFFFFFF);
        send_data(8'h00);                            // code runs into the next byte
        send_data(8'h01);
        send_load(HEAD_NODE, NODE_BASE + 9'd253, 9'd510); // head bit 1 loops on itself
        send_data(8'hFF);
        send_data(8'hFF);                            // byte without any symbol
        send_data(8'h5C);
        send_start(24'd1);
        send_data(8'h00);
        send_load(HEAD_NODE, NODE_BASE + 9'd253, 9'h5A);

        // Random part: mostly well-formed runs of a few node writes, a chunk
        // start and one to eight bytes for it, with some noise mixed in.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            loads = $urandom_range(0, 3);
            for (k = 0; k < loads; k++)
                load_random_node();
            random_sent += loads;

            r = $urandom_range(0, 9);
            if (r == 0)
                len = '0;
            else if (r < 8)
                len = EXPAND_W'($urandom_range(1, 24));
            else
                len = EXPAND_W'($urandom_range(0, 24'hFFFFFF));
            send_start(len);
            bytes = (len > 24) ? 8 : $urandom_range(1, 8);
            for (k = 0; k < bytes; k++)
                send_data(BYTE_W'($urandom_range(0, 255)));
            random_sent += bytes + 1;

            if ($urandom_range(0, 9) == 0) begin
                send_item(OP_NONE, random_payload());
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let the checker register the last item, then wait for the symbols
        // still owed and a little longer for anything that should not come.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
